[hw/rtl/savgol_smoothing_filter_defines.svh]
// Assertion macros for the savitzky-golay smoothing filter.
// Used by the top level; the including module must have clk and rst_n.
`ifndef SAVGOL_SMOOTHING_FILTER_DEFINES_SVH
`define SAVGOL_SMOOTHING_FILTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SGSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SGSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sgsf_pkg.sv]
// Shared types, constants and coefficient lookup for the smoothing filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sgsf_pkg;

  // geometry
  localparam int WINDOW     = 5;
  localparam int HIST_DEPTH = WINDOW - 1;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 17;
  localparam int OUT_W      = 33;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = (SAMPLE_W + COEF_W + 2 > OUT_W + 1) ?
                              (SAMPLE_W + COEF_W + 2) : (OUT_W + 1);
  localparam int TAP_W      = $clog2(WINDOW);
  localparam int MODE_W     = 2;
  localparam int SEEN_W     = 2;

  // derivative mode codes
  localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DERIV1 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DERIV2 = 2'd2;

  // frame position codes
  localparam logic [SEEN_W-1:0] SEEN_NONE   = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_THIRD  = 2'd2;
  localparam logic [SEEN_W-1:0] SEEN_STEADY = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [WINDOW-1:0][SAMPLE_W-1:0]     win_t;
  typedef logic [HIST_DEPTH-1:0][SAMPLE_W-1:0] hist_t;

  // input and result beats
  typedef struct packed {
    sample_t sample;
    logic    frame_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    result_last;
    logic                    short_frame;
  } out_beat_t;

  // beat travelling down the cell chain
  typedef struct packed {
    win_t                    win;
    logic signed [ACC_W-1:0] acc;
    logic                    last;
    logic                    short_flag;
  } cell_beat_t;

  // front end status
  typedef struct packed {
    logic              flushing;
    logic [SEEN_W-1:0] seen;
  } front_stat_t;

  typedef enum logic [1:0] {
    FS_RUN,
    FS_FLUSH_A,
    FS_FLUSH_B
  } flush_state_t;

  // coefficient rows, exact fractions rounded to 2^-16
  localparam coef_t SMOOTH_C [WINDOW] = '{coef_t'(-5617), coef_t'(22469),
    coef_t'(31832), coef_t'(22469), coef_t'(-5617)};
  localparam coef_t DERIV1_C [WINDOW] = '{coef_t'(-13107), coef_t'(-6554),
    coef_t'(0), coef_t'(6554), coef_t'(13107)};
  localparam coef_t DERIV2_C [WINDOW] = '{coef_t'(18725), coef_t'(-9362),
    coef_t'(-18725), coef_t'(-9362), coef_t'(18725)};

  function automatic coef_t coef_of(input logic [MODE_W-1:0] mode,
                                    input logic [TAP_W-1:0]  tap);
    coef_t c;
    c = '0;
    unique case (mode)
      MODE_SMOOTH: c = SMOOTH_C[tap];
      MODE_DERIV1: c = DERIV1_C[tap];
      MODE_DERIV2: c = DERIV2_C[tap];
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/savgol_smoothing_filter.sv]
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   in_beat_t  (sample, frame_end)
// out_     output     out_valid/out_stall out_beat_t (filtered, result_last, short_frame)
// cfg_     input      cfg_valid/cfg_ready derivative mode, 2 bits
//
// Takes one sample a cycle while in_stall is low; a frame-closing sample with a
// full window holds in_stall while the front end flushes the frame end.
// The data path is five tap cells, then the output register.
// rst_n is synchronous: clears valids, history, frame position and mode.
// out_stall backs up through the cell chain one stage at a time; empty stages
// still take beats, so outside a flush input stalls only when the whole chain is full.
//
// Top level of the five-point savitzky-golay filter.
// Depends on sgsf_pkg, sgsf_front, sgsf_cell, sgsf_out and the defines header.
`timescale 1ns / 1ps
`include "savgol_smoothing_filter_defines.svh"

module savgol_smoothing_filter import sgsf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_beat_t          in_data,
  output logic              in_stall,
  output logic              out_valid,
  output out_beat_t         out_data,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MODE_W-1:0] cfg_derivative_mode
);

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              cv [WINDOW+1];
  logic              cr [WINDOW+1];
  cell_beat_t        cb [WINDOW+1];
  front_stat_t       front_st;

  // configuration register
  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_derivative_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SMOOTH;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // history and flush
  sgsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .dn_valid (cv[0]),
    .dn_beat  (cb[0]),
    .dn_ready (cr[0]),
    .stat     (front_st)
  );

  // tap chain
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    sgsf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .coef     (coef_of(mode_r, TAP_W'(k))),
      .up_valid (cv[k]),
      .up_beat  (cb[k]),
      .up_ready (cr[k]),
      .dn_valid (cv[k+1]),
      .dn_beat  (cb[k+1]),
      .dn_ready (cr[k+1])
    );
  end

  // result register
  sgsf_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cv[WINDOW]),
    .up_beat   (cb[WINDOW]),
    .up_ready  (cr[WINDOW]),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // checks
  `SGSF_ASSERT_NOW(a_short_result, out_valid && out_data.short_frame,
    out_data.result_last && (out_data.filtered == '0), "short result not last or not zero")
  `SGSF_ASSERT_NEXT(a_flush_holds_input,
    in_valid && !in_stall && in_data.frame_end && front_st.seen[1],
    in_stall && front_st.flushing, "frame end flush did not hold input")
  `SGSF_ASSERT_NEXT(a_frame_close, in_valid && !in_stall && in_data.frame_end,
    front_st.seen == SEEN_NONE, "frame position not cleared at frame end")

endmodule

[hw/rtl/sgsf_front.sv]
// Front end: sample history, edge reflection and end-of-frame flush.
// Depends on sgsf_pkg; feeds the first multiply cell.
`timescale 1ns / 1ps

module sgsf_front import sgsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_beat_t    in_data,
  output logic        in_stall,
  output logic        dn_valid,
  output cell_beat_t  dn_beat,
  input  logic        dn_ready,
  output front_stat_t stat
);

  flush_state_t      state_r, state_nxt;
  hist_t             hist_r, hist_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  win_t              fwin_r, fwin_nxt;
  win_t              run_win;
  logic              accept;

  assign in_stall      = (state_r != FS_RUN) || !dn_ready;
  assign accept        = in_valid && !in_stall;
  assign stat.flushing = (state_r != FS_RUN);
  assign stat.seen     = seen_r;

  // window for a sample in mid frame, reflected at the frame start
  always_comb begin
    if (seen_r == SEEN_THIRD) begin
      run_win[0] = in_data.sample;
      run_win[1] = hist_r[3];
      run_win[2] = hist_r[2];
      run_win[3] = hist_r[3];
      run_win[4] = in_data.sample;
    end else begin
      run_win[0] = hist_r[0];
      run_win[1] = hist_r[1];
      run_win[2] = hist_r[2];
      run_win[3] = hist_r[3];
      run_win[4] = in_data.sample;
    end
  end

  // next state, history update and beat to the cells
  always_comb begin
    state_nxt          = state_r;
    hist_nxt           = hist_r;
    seen_nxt           = seen_r;
    fwin_nxt           = fwin_r;
    dn_valid           = 1'b0;
    dn_beat.win        = run_win;
    dn_beat.acc        = '0;
    dn_beat.last       = 1'b0;
    dn_beat.short_flag = 1'b0;
    unique case (state_r)
      FS_RUN: begin
        dn_valid = in_valid && (seen_r[1] || in_data.frame_end);
        if (!seen_r[1]) begin
          // short frame result
          dn_beat.win        = '0;
          dn_beat.last       = 1'b1;
          dn_beat.short_flag = 1'b1;
        end
        if (accept) begin
          if (!seen_r[1]) begin
            if (in_data.frame_end) begin
              hist_nxt = '0;
              seen_nxt = SEEN_NONE;
            end else begin
              hist_nxt[0] = hist_r[1];
              hist_nxt[1] = hist_r[2];
              hist_nxt[2] = hist_r[3];
              hist_nxt[3] = in_data.sample;
              seen_nxt    = seen_r + 1'b1;
            end
          end else if (!in_data.frame_end) begin
            hist_nxt[0] = run_win[1];
            hist_nxt[1] = run_win[2];
            hist_nxt[2] = run_win[3];
            hist_nxt[3] = run_win[4];
            seen_nxt    = SEEN_STEADY;
          end else begin
            fwin_nxt  = run_win;
            hist_nxt  = '0;
            seen_nxt  = SEEN_NONE;
            state_nxt = FS_FLUSH_A;
          end
        end
      end
      FS_FLUSH_A: begin
        // reflected at the frame end, one sample short
        dn_valid       = 1'b1;
        dn_beat.win[0] = fwin_r[1];
        dn_beat.win[1] = fwin_r[2];
        dn_beat.win[2] = fwin_r[3];
        dn_beat.win[3] = fwin_r[4];
        dn_beat.win[4] = fwin_r[3];
        if (dn_ready) begin
          state_nxt = FS_FLUSH_B;
        end
      end
      FS_FLUSH_B: begin
        // final centre on the last sample
        dn_valid       = 1'b1;
        dn_beat.win[0] = fwin_r[2];
        dn_beat.win[1] = fwin_r[3];
        dn_beat.win[2] = fwin_r[4];
        dn_beat.win[3] = fwin_r[3];
        dn_beat.win[4] = fwin_r[2];
        dn_beat.last   = 1'b1;
        if (dn_ready) begin
          state_nxt = FS_RUN;
        end
      end
      default: begin
        state_nxt = FS_RUN;
      end
    endcase
  end

  // control and history registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_RUN;
      hist_r  <= '0;
      seen_r  <= SEEN_NONE;
    end else begin
      state_r <= state_nxt;
      hist_r  <= hist_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // saved window for the flush
  always_ff @(posedge clk) begin
    fwin_r <= fwin_nxt;
  end

endmodule

[hw/rtl/sgsf_cell.sv]
// One multiply-accumulate cell of the tap chain.
// Depends on sgsf_pkg; instantiated once per tap by the top level.
`timescale 1ns / 1ps

module sgsf_cell import sgsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  coef_t      coef,
  input  logic       up_valid,
  input  cell_beat_t up_beat,
  output logic       up_ready,
  output logic       dn_valid,
  output cell_beat_t dn_beat,
  input  logic       dn_ready
);

  logic                     valid_r, valid_nxt;
  cell_beat_t               beat_r, beat_nxt;
  logic signed [PROD_W-1:0] prod;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

  // use the head sample, pass the rest of the window on
  always_comb begin
    prod = $signed(up_beat.win[0]) * coef;
    beat_nxt = up_beat;
    for (int k = 0; k < WINDOW - 1; k++) begin
      beat_nxt.win[k] = up_beat.win[k+1];
    end
    beat_nxt.win[WINDOW-1] = '0;
    beat_nxt.acc = up_beat.acc + ACC_W'(prod);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

[hw/rtl/sgsf_out.sv]
// Output stage: saturation to the result width and the result register.
// Depends on sgsf_pkg; sits after the last tap cell.
`timescale 1ns / 1ps

module sgsf_out import sgsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_valid,
  input  cell_beat_t up_beat,
  output logic       up_ready,
  output logic       out_valid,
  output out_beat_t  out_data,
  input  logic       out_stall
);

  logic                    valid_r, valid_nxt;
  out_beat_t               data_r, data_nxt;
  logic [ACC_W-OUT_W:0]    top_bits;
  logic                    ovf;

  assign up_ready  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // clamp to the signed result range
  always_comb begin
    top_bits = up_beat.acc[ACC_W-1:OUT_W-1];
    ovf      = !((&top_bits) || !(|top_bits));
    data_nxt.result_last = up_beat.last;
    data_nxt.short_frame = up_beat.short_flag;
    if (!ovf) begin
      data_nxt.filtered = up_beat.acc[OUT_W-1:0];
    end else if (up_beat.acc[ACC_W-1]) begin
      data_nxt.filtered = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      data_nxt.filtered = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule
